// ===== design/ipwfe_pkg.sv =====
// Shared constants, types and helpers for the IR pulse-width frame encoder.
`default_nettype none

package ipwfe_pkg;

    // Bits sent per byte; bits above bit 7 of a byte go out as zero bits.
    localparam int BYTE_BITS = 8;

    localparam int BYTE_W    = 8;
    localparam int DUR_W     = 14;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = DUR_W;

    // Header mark + header space, two segments per bit for two bytes, gap space.
    localparam int SEG_COUNT = 2 + 4 * BYTE_BITS + 1;
    localparam int SEG_W     = $clog2(SEG_COUNT);
    localparam int IDX_W     = (BYTE_BITS > 1) ? $clog2(BYTE_BITS) : 1;

    localparam logic [SEG_W-1:0] SEG_HDR_MARK  = SEG_W'(0);
    localparam logic [SEG_W-1:0] SEG_HDR_SPACE = SEG_W'(1);
    localparam logic [SEG_W-1:0] SEG_LAST      = SEG_W'(SEG_COUNT - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HDR_MARK   = CFG_IDX_W'(0),
        REG_HDR_SPACE  = CFG_IDX_W'(1),
        REG_ONE_MARK   = CFG_IDX_W'(2),
        REG_ZERO_MARK  = CFG_IDX_W'(3),
        REG_ONE_SPACE  = CFG_IDX_W'(4),
        REG_ZERO_SPACE = CFG_IDX_W'(5),
        REG_GAP_SPACE  = CFG_IDX_W'(6),
        REG_START_BYTE = CFG_IDX_W'(7)
    } t_reg_idx;

    localparam logic [DUR_W-1:0]  RST_HDR_MARK   = DUR_W'(2400);
    localparam logic [DUR_W-1:0]  RST_HDR_SPACE  = DUR_W'(600);
    localparam logic [DUR_W-1:0]  RST_ONE_MARK   = DUR_W'(1200);
    localparam logic [DUR_W-1:0]  RST_ZERO_MARK  = DUR_W'(600);
    localparam logic [DUR_W-1:0]  RST_ONE_SPACE  = DUR_W'(600);
    localparam logic [DUR_W-1:0]  RST_ZERO_SPACE = DUR_W'(1200);
    localparam logic [DUR_W-1:0]  RST_GAP_SPACE  = DUR_W'(3000);
    localparam logic [BYTE_W-1:0] RST_START_BYTE = BYTE_W'(8'hAA);

    typedef struct packed {
        logic [DUR_W-1:0]  hdr_mark;
        logic [DUR_W-1:0]  hdr_space;
        logic [DUR_W-1:0]  one_mark;
        logic [DUR_W-1:0]  zero_mark;
        logic [DUR_W-1:0]  one_space;
        logic [DUR_W-1:0]  zero_space;
        logic [DUR_W-1:0]  gap_space;
        logic [BYTE_W-1:0] start_byte;
    } t_cfg;

    typedef struct packed {
        logic              active;
        logic [SEG_W-1:0]  seg;
        logic [BYTE_W-1:0] payload;
    } t_seq;

    // Spread an 8-bit byte over BYTE_BITS bit slots, zero above bit 7.
    function automatic logic [BYTE_BITS-1:0] widen_byte(input logic [BYTE_W-1:0] b);
        logic [15:0]          ext;
        logic [BYTE_BITS-1:0] v;
        ext = {8'h00, b};
        for (int i = 0; i < BYTE_BITS; i++) begin
            v[i] = ext[i];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/ir_pulse_width_frame_encoder_unit.sv =====
// Top level of the IR pulse-width frame encoder.
//
// Usage:
//   Command channel: a byte on i_payload_byte is taken at a clock edge where
//   i_start is high and o_busy is low. The frame comes out as one segment per
//   cycle on o_carrier_on / o_duration_us / o_last_segment, each marked by a
//   one-cycle o_strobe: header mark, header space, start byte and command
//   byte (LSB first, mark then space per bit), then the gap space with
//   o_last_segment set. 35 segments per byte.
//   The accepting edge loads the segment counter in ipwfe_seq; the result
//   register in ipwfe_seg_gen then puts each segment on the outputs.
//   Throughput: one byte per frame, set by the segment counter that
//   emits one segment per cycle; o_busy drops during the last segment so the
//   next frame follows with no idle cycle.
//   The receiver cannot stall: each segment is valid only in its strobe cycle.
//   Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//   selects the register, unmapped indexes are ignored. Write only when idle.
//   Reset (synchronous, active low) restores default timings and start byte
//   0xAA and drops any frame in progress.
`default_nettype none

module ir_pulse_width_frame_encoder_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    output logic                            o_busy,
    input  wire  [ipwfe_pkg::BYTE_W-1:0]    i_payload_byte,
    output logic                            o_strobe,
    output logic                            o_carrier_on,
    output logic [ipwfe_pkg::DUR_W-1:0]     o_duration_us,
    output logic                            o_last_segment,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [ipwfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [ipwfe_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import ipwfe_pkg::*;

    t_cfg cfg;
    t_seq seq;
    logic accept;

    assign accept = i_start && !o_busy;

    ipwfe_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ipwfe_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_payload_byte (i_payload_byte),
        .o_busy         (o_busy),
        .o_seq          (seq)
    );

    ipwfe_seg_gen u_seg_gen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seq          (seq),
        .i_cfg          (cfg),
        .o_strobe       (o_strobe),
        .o_carrier_on   (o_carrier_on),
        .o_duration_us  (o_duration_us),
        .o_last_segment (o_last_segment)
    );

    // A transfer restarts the frame at the header mark.
    a_accept_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (seq.active && seq.seg == SEG_HDR_MARK))
        else $error("accepted byte did not restart the segment counter");

    // Without a new byte the sequencer goes idle after the gap segment.
    a_frame_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq.active && seq.seg == SEG_LAST && !accept) |=> !seq.active)
        else $error("sequencer kept running past the gap segment");

    // Every strobed segment comes from an active sequencer cycle.
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(seq.active))
        else $error("result strobe without an active segment");

    // The closing segment is a space and only comes from the last counter value.
    a_last_is_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_segment) |-> (!o_carrier_on && $past(seq.seg) == SEG_LAST))
        else $error("last segment flag on a wrong segment");

endmodule

`default_nettype wire

// ===== design/ipwfe_cfg_regs.sv =====
// Configuration register file: segment timings and start byte.
`default_nettype none

module ipwfe_cfg_regs (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [ipwfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [ipwfe_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output ipwfe_pkg::t_cfg                o_cfg
);
    import ipwfe_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_HDR_MARK:   n_cfg.hdr_mark   = i_cfg_data;
                REG_HDR_SPACE:  n_cfg.hdr_space  = i_cfg_data;
                REG_ONE_MARK:   n_cfg.one_mark   = i_cfg_data;
                REG_ZERO_MARK:  n_cfg.zero_mark  = i_cfg_data;
                REG_ONE_SPACE:  n_cfg.one_space  = i_cfg_data;
                REG_ZERO_SPACE: n_cfg.zero_space = i_cfg_data;
                REG_GAP_SPACE:  n_cfg.gap_space  = i_cfg_data;
                REG_START_BYTE: n_cfg.start_byte = i_cfg_data[BYTE_W-1:0];
                default:        n_cfg = r_cfg; // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_mark   <= RST_HDR_MARK;
            r_cfg.hdr_space  <= RST_HDR_SPACE;
            r_cfg.one_mark   <= RST_ONE_MARK;
            r_cfg.zero_mark  <= RST_ZERO_MARK;
            r_cfg.one_space  <= RST_ONE_SPACE;
            r_cfg.zero_space <= RST_ZERO_SPACE;
            r_cfg.gap_space  <= RST_GAP_SPACE;
            r_cfg.start_byte <= RST_START_BYTE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== design/ipwfe_seq.sv =====
// Frame sequencer: captures the command byte and steps the segment counter.
`default_nettype none

module ipwfe_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [ipwfe_pkg::BYTE_W-1:0] i_payload_byte,
    output logic                         o_busy,
    output ipwfe_pkg::t_seq              o_seq
);
    import ipwfe_pkg::*;

    logic              r_active;
    logic [SEG_W-1:0]  r_seg;
    logic [BYTE_W-1:0] r_payload;
    logic              n_active;
    logic [SEG_W-1:0]  n_seg;
    logic              accept;

    // Free during the final segment so the next frame follows without a gap.
    assign o_busy = r_active && (r_seg != SEG_LAST);
    assign accept = i_start && !o_busy;

    always_comb begin
        n_active = r_active;
        n_seg    = r_seg;
        if (accept) begin
            n_active = 1'b1;
            n_seg    = SEG_HDR_MARK;
        end else if (r_active) begin
            if (r_seg == SEG_LAST) begin
                n_active = 1'b0;
            end else begin
                n_seg = r_seg + SEG_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_seg    <= SEG_HDR_MARK;
        end else begin
            r_active <= n_active;
            r_seg    <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_payload <= i_payload_byte;
        end
    end

    assign o_seq.active  = r_active;
    assign o_seq.seg     = r_seg;
    assign o_seq.payload = r_payload;

endmodule

`default_nettype wire

// ===== design/ipwfe_seg_gen.sv =====
// Segment decoder and result register: maps a segment number to mark/space and duration.
`default_nettype none

module ipwfe_seg_gen (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  ipwfe_pkg::t_seq             i_seq,
    input  ipwfe_pkg::t_cfg             i_cfg,
    output logic                        o_strobe,
    output logic                        o_carrier_on,
    output logic [ipwfe_pkg::DUR_W-1:0] o_duration_us,
    output logic                        o_last_segment
);
    import ipwfe_pkg::*;

    logic [SEG_W-1:0]     off;
    logic [SEG_W-1:0]     off2;
    logic [SEG_W-1:0]     half;
    logic [IDX_W-1:0]     idx;
    logic                 sel_payload;
    logic                 bit_val;
    logic [BYTE_BITS-1:0] start_v;
    logic [BYTE_BITS-1:0] pay_v;

    logic                 n_carrier;
    logic [DUR_W-1:0]     n_dur;
    logic                 n_last;

    logic                 r_strobe;
    logic                 r_carrier;
    logic [DUR_W-1:0]     r_dur;
    logic                 r_last;

    assign start_v = widen_byte(i_cfg.start_byte);
    assign pay_v   = widen_byte(i_seq.payload);

    // Bit segments start after the header; the second byte starts 2*BYTE_BITS later.
    assign off         = i_seq.seg - SEG_W'(2);
    assign sel_payload = off >= SEG_W'(2 * BYTE_BITS);
    assign off2        = sel_payload ? off - SEG_W'(2 * BYTE_BITS) : off;
    assign half        = off2 >> 1;
    assign idx         = half[IDX_W-1:0];
    assign bit_val     = sel_payload ? pay_v[idx] : start_v[idx];

    always_comb begin
        n_last = 1'b0;
        if (i_seq.seg == SEG_HDR_MARK) begin
            n_carrier = 1'b1;
            n_dur     = i_cfg.hdr_mark;
        end else if (i_seq.seg == SEG_HDR_SPACE) begin
            n_carrier = 1'b0;
            n_dur     = i_cfg.hdr_space;
        end else if (i_seq.seg == SEG_LAST) begin
            n_carrier = 1'b0;
            n_dur     = i_cfg.gap_space;
            n_last    = 1'b1;
        end else if (!off2[0]) begin
            n_carrier = 1'b1;
            n_dur     = bit_val ? i_cfg.one_mark : i_cfg.zero_mark;
        end else begin
            n_carrier = 1'b0;
            n_dur     = bit_val ? i_cfg.one_space : i_cfg.zero_space;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_seq.active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carrier <= n_carrier;
        r_dur     <= n_dur;
        r_last    <= n_last;
    end

    assign o_strobe       = r_strobe;
    assign o_carrier_on   = r_carrier;
    assign o_duration_us  = r_dur;
    assign o_last_segment = r_last;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the IR pulse-width frame encoder: random and directed bytes and timings.
module testbench;
    import ipwfe_pkg::*;

    localparam int REG_COUNT    = 8;
    localparam int STALL_LIMIT  = 600;
    localparam int RANDOM_SETS  = 9;
    localparam int BYTES_PER_SET = 50;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(REG_COUNT);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;
    localparam logic [DUR_W-1:0]     DUR_MAX         = '1;

    typedef struct packed {
        logic             carrier;
        logic [DUR_W-1:0] duration;
        logic             closing;
    } t_segment;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_start        = 1'b0;
    logic [BYTE_W-1:0]    i_payload_byte = '0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data     = '0;
    logic                 o_busy;
    logic                 o_strobe;
    logic                 o_carrier_on;
    logic [DUR_W-1:0]     o_duration_us;
    logic                 o_last_segment;
    logic                 o_cfg_ready;

    t_cfg              timing;
    t_segment          expected_segments[$];
    logic [BYTE_W-1:0] byte_queue[$];
    int                bytes_queued = 0;
    int                bytes_taken  = 0;
    int                fault_count  = 0;
    int                idle_left    = 0;
    int                quiet_cycles = 0;
    bit                steady       = 1'b0;

    ir_pulse_width_frame_encoder_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_payload_byte (i_payload_byte),
        .o_strobe       (o_strobe),
        .o_carrier_on   (o_carrier_on),
        .o_duration_us  (o_duration_us),
        .o_last_segment (o_last_segment),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---- frame predictor ----
    function automatic void push_seg(input logic on, input logic [DUR_W-1:0] dur,
                                     input logic fin);
        t_segment s;
        s.carrier  = on;
        s.duration = dur;
        s.closing  = fin;
        expected_segments.push_back(s);
    endfunction

    // LSB first; bit slots above bit 7 go out as zero bits
    function automatic void push_byte_bits(input logic [BYTE_W-1:0] b);
        logic [15:0] ext;
        ext = {8'h00, b};
        for (int i = 0; i < BYTE_BITS; i++) begin
            if (ext[i]) begin
                push_seg(1'b1, timing.one_mark, 1'b0);
                push_seg(1'b0, timing.one_space, 1'b0);
            end else begin
                push_seg(1'b1, timing.zero_mark, 1'b0);
                push_seg(1'b0, timing.zero_space, 1'b0);
            end
        end
    endfunction

    function automatic void build_frame(input logic [BYTE_W-1:0] payload);
        push_seg(1'b1, timing.hdr_mark, 1'b0);
        push_seg(1'b0, timing.hdr_space, 1'b0);
        push_byte_bits(timing.start_byte);
        push_byte_bits(payload);
        push_seg(1'b0, timing.gap_space, 1'b1);
    endfunction

    task automatic flag_error(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // ---- register shadow, updated on each config transfer ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timing.hdr_mark   = RST_HDR_MARK;
            timing.hdr_space  = RST_HDR_SPACE;
            timing.one_mark   = RST_ONE_MARK;
            timing.zero_mark  = RST_ZERO_MARK;
            timing.one_space  = RST_ONE_SPACE;
            timing.zero_space = RST_ZERO_SPACE;
            timing.gap_space  = RST_GAP_SPACE;
            timing.start_byte = RST_START_BYTE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HDR_MARK:   timing.hdr_mark   = i_cfg_data;
                REG_HDR_SPACE:  timing.hdr_space  = i_cfg_data;
                REG_ONE_MARK:   timing.one_mark   = i_cfg_data;
                REG_ZERO_MARK:  timing.zero_mark  = i_cfg_data;
                REG_ONE_SPACE:  timing.one_space  = i_cfg_data;
                REG_ZERO_SPACE: timing.zero_space = i_cfg_data;
                REG_GAP_SPACE:  timing.gap_space  = i_cfg_data;
                REG_START_BYTE: timing.start_byte = i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- command driver ----
    always @(posedge i_clk) begin : drive
        logic took;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            idle_left = 0;
        end else begin
            took = i_start && !o_busy;
            if (took) begin
                build_frame(i_payload_byte);
                bytes_taken++;
                if (!steady && $urandom_range(0, 2) == 0)
                    idle_left = $urandom_range(1, 14);
            end
            // hold start while the block is busy; otherwise load the next byte
            if (took || !i_start) begin
                if (idle_left > 0) begin
                    if (!took && !o_busy)
                        idle_left--;
                    i_start <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    i_start        <= 1'b1;
                    i_payload_byte <= byte_queue.pop_front();
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // ---- segment monitor ----
    always @(posedge i_clk) begin : watch
        t_segment want;
        if (i_rst_n && o_strobe) begin
            if (expected_segments.size() == 0) begin
                flag_error($sformatf("unexpected segment carrier=%0b dur=%0d last=%0b",
                                     o_carrier_on, o_duration_us, o_last_segment));
            end else begin
                want = expected_segments.pop_front();
                if (o_carrier_on !== want.carrier)
                    flag_error($sformatf("carrier_on exp %0b got %0b",
                                         want.carrier, o_carrier_on));
                if (o_duration_us !== want.duration)
                    flag_error($sformatf("duration_us exp %0d got %0d",
                                         want.duration, o_duration_us));
                if (o_last_segment !== want.closing)
                    flag_error($sformatf("last_segment exp %0b got %0b",
                                         want.closing, o_last_segment));
            end
        end
    end

    // ---- watchdog: cycles with no command or config transfer ----
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // ---- stimulus ----
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        byte_queue.push_back(b);
        bytes_queued++;
    endtask

    task automatic drain();
        while (bytes_taken != bytes_queued || expected_segments.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_timing(input logic [DUR_W-1:0] hm, input logic [DUR_W-1:0] hs,
                               input logic [DUR_W-1:0] om, input logic [DUR_W-1:0] zm,
                               input logic [DUR_W-1:0] os, input logic [DUR_W-1:0] zs,
                               input logic [DUR_W-1:0] gs, input logic [CFG_DAT_W-1:0] sb);
        write_reg(REG_HDR_MARK, hm);
        write_reg(REG_HDR_SPACE, hs);
        write_reg(REG_ONE_MARK, om);
        write_reg(REG_ZERO_MARK, zm);
        write_reg(REG_ONE_SPACE, os);
        write_reg(REG_ZERO_SPACE, zs);
        write_reg(REG_GAP_SPACE, gs);
        write_reg(REG_START_BYTE, sb);
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return DUR_MAX;
            2:       return DUR_W'($urandom_range(1, 50));
            default: return DUR_W'($urandom_range(0, 16383));
        endcase
    endfunction

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset timings: all-zero, all-one, single-bit and alternating payloads
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h55);
        send_byte(8'hAA);
        drain();

        // zero-length segments everywhere
        load_timing('0, '0, '0, '0, '0, '0, '0, '0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h5A);
        drain();

        // full-scale durations; start byte write carries extra high bits
        load_timing(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, '1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        drain();

        // distinct value per register, writes to unmapped indexes must be dropped
        load_timing(14'd1, 14'd2, 14'd3, 14'd4, 14'd5, 14'd6, 14'd7, 14'h3F00);
        write_reg(REG_UNMAPPED_LO, 14'h1234);
        write_reg(REG_UNMAPPED_HI, DUR_MAX);
        send_byte(8'h0F);
        send_byte(8'hF0);
        send_byte(8'h3C);
        send_byte(8'hC3);
        drain();

        for (int p = 0; p < RANDOM_SETS; p++) begin
            steady = (p == 4 || p == RANDOM_SETS - 1);
            load_timing(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                        pick_duration(), pick_duration(), pick_duration(),
                        CFG_DAT_W'($urandom_range(0, 16383)));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)),
                          CFG_DAT_W'($urandom_range(0, 16383)));
            for (int n = 0; n < BYTES_PER_SET; n++)
                send_byte(BYTE_W'($urandom_range(0, 255)));
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/ipwfe_pkg.sv
design/ipwfe_cfg_regs.sv
design/ipwfe_seq.sv
design/ipwfe_seg_gen.sv
design/ir_pulse_width_frame_encoder_unit.sv
tb/sv/testbench.sv
